// File: sv/bahai_pkg.sv
package bahai_pkg;

    localparam int unsigned DAY_W   = 22;
    localparam int unsigned YEAR_W  = 13;
    localparam int unsigned MONTH_W = 5;
    localparam int unsigned MDAY_W  = 5;

    localparam int unsigned EPOCH_GREG_YEAR = 1844;
    localparam int unsigned EPOCH_P         = EPOCH_GREG_YEAR - 1;
    localparam int unsigned EPOCH_DAY       = 365 * EPOCH_P + EPOCH_P / 4 - EPOCH_P / 100
                                              + EPOCH_P / 400 + 31 + 29 + 21;

    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_100Y = 36524;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned DAYS_1Y   = 365;

    localparam int unsigned RECIP_K    = 24;
    localparam int unsigned RECIP_400Y = (1 << RECIP_K) / DAYS_400Y;
    localparam int unsigned RECIP_4Y   = (1 << RECIP_K) / DAYS_4Y;
    localparam int unsigned RECIP_C100 = ((1 << RECIP_K) + 99) / 100;

    localparam int unsigned DAYS_PER_MONTH  = 19;
    localparam int unsigned REGULAR_MONTHS  = 18;
    localparam int unsigned REGULAR_DAYS    = DAYS_PER_MONTH * REGULAR_MONTHS;
    localparam int unsigned LAST_MONTH_BASE = DAYS_1Y - DAYS_PER_MONTH;
    localparam int unsigned MONTH_RECIP_K   = 12;
    localparam int unsigned MONTH_RECIP     = ((1 << MONTH_RECIP_K) + DAYS_PER_MONTH - 1)
                                              / DAYS_PER_MONTH;

    localparam int unsigned MONTH_INTERCALARY = 19;
    localparam int unsigned MONTH_LAST        = 20;

endpackage

// File: sv/bahai_if.sv
interface bahai_in_if;
    logic                            valid;
    logic                            ready;
    logic [bahai_pkg::DAY_W-1:0]     day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

interface bahai_out_if;
    logic                            valid;
    logic                            ready;
    logic                            before_epoch;
    logic [bahai_pkg::YEAR_W-1:0]    bahai_year;
    logic [bahai_pkg::MONTH_W-1:0]   bahai_month;
    logic [bahai_pkg::MDAY_W-1:0]    bahai_day;

    modport source (output valid, output before_epoch, output bahai_year,
                    output bahai_month, output bahai_day, input ready);
    modport sink   (input valid, input before_epoch, input bahai_year,
                    input bahai_month, input bahai_day, output ready);
endinterface

// File: sv/bahai_date_from_day_number_unit.sv
// Channel | Port  | Direction | Payload
// --------+-------+-----------+---------------------------------------------------
// input   | i_in  | sink      | day_number
// output  | o_out | source    | before_epoch, bahai_year, bahai_month, bahai_day
//
// Ten register stages, the last one the output register; one transaction is accepted
// every cycle while the output side is not stalled.
// The stages split the day count into 400, 100, 4 and 1 year periods, find 21 March
// of the year, then the month and day; constant divisions use reciprocal multiplies.
// Synchronous active-low reset clears the valid bits only.
// A stage loads when it is empty or the stage after it moves; bubbles close up.
module bahai_date_from_day_number_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bahai_in_if.sink    i_in,
    bahai_out_if.source o_out
);

    localparam int unsigned NSTG = 10;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;

    always_comb begin
        en[NSTG] = !r_vld[NSTG] || o_out.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: 400-year estimate
    logic [21:0] d0;
    logic [28:0] q400_prod;
    logic [21:0] r_s1_day, r_s1_d0;
    logic        r_s1_pre;
    logic [4:0]  r_s1_q;

    assign d0        = i_in.day_number - 22'd1;
    assign q400_prod = 29'(d0) * 29'(bahai_pkg::RECIP_400Y);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_day <= i_in.day_number;
            r_s1_d0  <= d0;
            r_s1_pre <= i_in.day_number < 22'(bahai_pkg::EPOCH_DAY);
            r_s1_q   <= 5'(q400_prod >> bahai_pkg::RECIP_K);
        end
    end

    // stage 2: 400-year correct
    logic [21:0] r1_raw;
    logic        r1_fix;
    logic [21:0] r_s2_day;
    logic        r_s2_pre;
    logic [4:0]  r_s2_n400;
    logic [17:0] r_s2_r1;

    assign r1_raw = r_s1_d0 - 22'(r_s1_q) * 22'(bahai_pkg::DAYS_400Y);
    assign r1_fix = r1_raw >= 22'(bahai_pkg::DAYS_400Y);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_day  <= r_s1_day;
            r_s2_pre  <= r_s1_pre;
            r_s2_n400 <= r_s1_q + 5'(r1_fix);
            r_s2_r1   <= r1_fix ? 18'(r1_raw - 22'(bahai_pkg::DAYS_400Y)) : 18'(r1_raw);
        end
    end

    // stage 3: 100-year split
    logic [2:0]  n100;
    logic [21:0] r_s3_day;
    logic        r_s3_pre;
    logic [4:0]  r_s3_n400;
    logic [2:0]  r_s3_n100;
    logic [15:0] r_s3_r2;

    always_comb begin
        n100 = '0;
        for (int k = 1; k <= 4; k++) begin
            if (r_s2_r1 >= 18'(k * bahai_pkg::DAYS_100Y)) begin
                n100 = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_day  <= r_s2_day;
            r_s3_pre  <= r_s2_pre;
            r_s3_n400 <= r_s2_n400;
            r_s3_n100 <= n100;
            r_s3_r2   <= 16'(r_s2_r1 - 18'(n100) * 18'(bahai_pkg::DAYS_100Y));
        end
    end

    // stage 4: 4-year estimate
    logic [29:0] q4_prod;
    logic [21:0] r_s4_day;
    logic        r_s4_pre;
    logic [4:0]  r_s4_n400;
    logic [2:0]  r_s4_n100;
    logic [15:0] r_s4_r2;
    logic [4:0]  r_s4_q;

    assign q4_prod = 30'(r_s3_r2) * 30'(bahai_pkg::RECIP_4Y);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_day  <= r_s3_day;
            r_s4_pre  <= r_s3_pre;
            r_s4_n400 <= r_s3_n400;
            r_s4_n100 <= r_s3_n100;
            r_s4_r2   <= r_s3_r2;
            r_s4_q    <= 5'(q4_prod >> bahai_pkg::RECIP_K);
        end
    end

    // stage 5: 4-year correct
    logic [15:0] r3_raw;
    logic        r3_fix;
    logic [21:0] r_s5_day;
    logic        r_s5_pre;
    logic [4:0]  r_s5_n400;
    logic [2:0]  r_s5_n100;
    logic [4:0]  r_s5_n4;
    logic [10:0] r_s5_r3;

    assign r3_raw = r_s4_r2 - 16'(r_s4_q) * 16'(bahai_pkg::DAYS_4Y);
    assign r3_fix = r3_raw >= 16'(bahai_pkg::DAYS_4Y);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_day  <= r_s4_day;
            r_s5_pre  <= r_s4_pre;
            r_s5_n400 <= r_s4_n400;
            r_s5_n100 <= r_s4_n100;
            r_s5_n4   <= r_s4_q + 5'(r3_fix);
            r_s5_r3   <= r3_fix ? 11'(r3_raw - 16'(bahai_pkg::DAYS_4Y)) : 11'(r3_raw);
        end
    end

    // stage 6: single years, Gregorian year minus one
    logic [2:0]  n1;
    logic [13:0] yr;
    logic [21:0] r_s6_day;
    logic        r_s6_pre;
    logic [13:0] r_s6_p;

    always_comb begin
        n1 = '0;
        for (int k = 1; k <= 4; k++) begin
            if (r_s5_r3 >= 11'(k * bahai_pkg::DAYS_1Y)) begin
                n1 = 3'(k);
            end
        end
    end

    assign yr = 14'(r_s5_n400) * 14'd400 + 14'(r_s5_n100) * 14'd100
              + 14'(r_s5_n4) * 14'd4 + 14'(n1);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_day <= r_s5_day;
            r_s6_pre <= r_s5_pre;
            r_s6_p   <= (r_s5_n100 == 3'd4 || n1 == 3'd4) ? yr - 14'd1 : yr;
        end
    end

    // stage 7: century quotient
    logic [31:0] q100_prod;
    logic [21:0] r_s7_day;
    logic        r_s7_pre;
    logic [13:0] r_s7_p;
    logic [7:0]  r_s7_q100;

    assign q100_prod = 32'(r_s6_p) * 32'(bahai_pkg::RECIP_C100);

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_day  <= r_s6_day;
            r_s7_pre  <= r_s6_pre;
            r_s7_p    <= r_s6_p;
            r_s7_q100 <= 8'(q100_prod >> bahai_pkg::RECIP_K);
        end
    end

    // stage 8: leap flags, 21 March of the year
    logic [6:0]  r100;
    logic        c1, c2;
    logic [7:0]  q1, q2;
    logic        leap0, leap1;
    logic [22:0] start0;
    logic [21:0] r_s8_day;
    logic        r_s8_pre;
    logic [13:0] r_s8_p;
    logic        r_s8_lg0, r_s8_lg1;
    logic [22:0] r_s8_start;

    assign r100   = 7'(r_s7_p - 14'(r_s7_q100) * 14'd100);
    assign c1     = r100 == 7'd99;
    assign c2     = r100 >= 7'd98;
    assign q1     = r_s7_q100 + 8'(c1);
    assign q2     = r_s7_q100 + 8'(c2);
    assign leap0  = (r_s7_p[1:0] == 2'd3) && (!c1 || q1[1:0] == 2'd0);
    assign leap1  = (r_s7_p[1:0] == 2'd2) && (r100 != 7'd98 || q2[1:0] == 2'd0);
    assign start0 = 23'(r_s7_p) * 23'(bahai_pkg::DAYS_1Y) + 23'(r_s7_p >> 2)
                  - 23'(r_s7_q100) + 23'(r_s7_q100 >> 2) + 23'd80 + 23'(leap0);

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_day   <= r_s7_day;
            r_s8_pre   <= r_s7_pre;
            r_s8_p     <= r_s7_p;
            r_s8_lg0   <= leap0;
            r_s8_lg1   <= leap1;
            r_s8_start <= start0;
        end
    end

    // stage 9: pick the year, offset into it
    logic [23:0] diff;
    logic        late;
    logic [12:0] byear;
    logic        r_s9_pre;
    logic [12:0] r_s9_year;
    logic        r_s9_leap;
    logic [8:0]  r_s9_off;

    assign diff  = 24'(r_s8_day) - 24'(r_s8_start);
    assign late  = diff[23];
    assign byear = late ? 13'(r_s8_p - 14'(bahai_pkg::EPOCH_GREG_YEAR - 1))
                        : 13'(r_s8_p - 14'(bahai_pkg::EPOCH_GREG_YEAR - 2));

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_pre  <= r_s8_pre;
            r_s9_year <= byear;
            r_s9_leap <= (byear != 13'd1) && (late ? r_s8_lg0 : r_s8_lg1);
            r_s9_off  <= late ? diff[8:0] + 9'(bahai_pkg::DAYS_1Y) + 9'(r_s8_lg0) : diff[8:0];
        end
    end

    // stage 10: month and day, output register
    logic [8:0]  last_base;
    logic [16:0] mq_prod;
    logic [4:0]  mq;
    logic [4:0]  month;
    logic [4:0]  mday;
    logic        r_o_pre;
    logic [12:0] r_o_year;
    logic [4:0]  r_o_month;
    logic [4:0]  r_o_day;

    assign last_base = 9'(bahai_pkg::LAST_MONTH_BASE) + 9'(r_s9_leap);
    assign mq_prod   = 17'(r_s9_off) * 17'(bahai_pkg::MONTH_RECIP);
    assign mq        = 5'(mq_prod >> bahai_pkg::MONTH_RECIP_K);

    always_comb begin
        if (r_s9_off >= last_base) begin
            month = 5'(bahai_pkg::MONTH_LAST);
            mday  = 5'(r_s9_off - last_base + 9'd1);
        end else if (r_s9_off >= 9'(bahai_pkg::REGULAR_DAYS)) begin
            month = 5'(bahai_pkg::MONTH_INTERCALARY);
            mday  = 5'(r_s9_off - 9'(bahai_pkg::REGULAR_DAYS) + 9'd1);
        end else begin
            month = mq + 5'd1;
            mday  = 5'(r_s9_off - 9'(mq) * 9'(bahai_pkg::DAYS_PER_MONTH) + 9'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_o_pre   <= r_s9_pre;
            r_o_year  <= r_s9_pre ? '0 : r_s9_year;
            r_o_month <= r_s9_pre ? '0 : month;
            r_o_day   <= r_s9_pre ? '0 : mday;
        end
    end

    assign o_out.valid        = r_vld[NSTG];
    assign o_out.before_epoch = r_o_pre;
    assign o_out.bahai_year   = r_o_year;
    assign o_out.bahai_month  = r_o_month;
    assign o_out.bahai_day    = r_o_day;

endmodule

// File: test/testbench.sv
module testbench;

    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_DAY      = 3652059;
    localparam int unsigned PIPE_DEPTH   = 10;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    typedef logic [bahai_pkg::DAY_W-1:0]   t_day;
    typedef logic [bahai_pkg::YEAR_W-1:0]  t_year;
    typedef logic [bahai_pkg::MONTH_W-1:0] t_month;
    typedef logic [bahai_pkg::MDAY_W-1:0]  t_mday;

    typedef struct packed {
        t_day   day_number;
        logic   before_epoch;
        t_year  year;
        t_month month;
        t_mday  mday;
    } t_bahai_date;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bahai_in_if  day_chan();
    bahai_out_if date_chan();

    bahai_date_from_day_number_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (day_chan),
        .o_out   (date_chan)
    );

    t_day             day_queue[$];
    t_bahai_date      dates_expected[$];
    int unsigned      total_days;
    int unsigned      days_sent = 0;
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    t_idle_phase      phase = PH_STEADY;
    bit               drain_pending = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic bit greg_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned march21_day(int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + 31 + (greg_leap(y) ? 29 : 28) + 21;
    endfunction

    function automatic t_bahai_date predict_bahai_date(t_day day_in);
        t_bahai_date       d;
        int unsigned       day, gy, start, len, offset, year_no, month, mday;
        longint unsigned   estimate;
        d = '0;
        d.day_number = day_in;
        day = 32'(day_in);
        if (day < march21_day(bahai_pkg::EPOCH_GREG_YEAR)) begin
            d.before_epoch = 1'b1;
            return d;
        end
        estimate = longint'(day) * 400 / 146097 + 1;
        gy = int'(estimate);
        while (march21_day(gy) > day) gy--;
        while (march21_day(gy + 1) <= day) gy++;
        start   = march21_day(gy);
        year_no = gy - (bahai_pkg::EPOCH_GREG_YEAR - 1);
        len     = (year_no != 1 && greg_leap(gy + 1)) ? 366 : 365;
        offset  = day - start;
        if (offset >= len - bahai_pkg::DAYS_PER_MONTH) begin
            month = bahai_pkg::MONTH_LAST;
            mday  = offset - (len - bahai_pkg::DAYS_PER_MONTH) + 1;
        end else if (offset >= bahai_pkg::DAYS_PER_MONTH * bahai_pkg::REGULAR_MONTHS) begin
            month = bahai_pkg::MONTH_INTERCALARY;
            mday  = offset - bahai_pkg::DAYS_PER_MONTH * bahai_pkg::REGULAR_MONTHS + 1;
        end else begin
            month = offset / bahai_pkg::DAYS_PER_MONTH + 1;
            mday  = offset % bahai_pkg::DAYS_PER_MONTH + 1;
        end
        d.year  = t_year'(year_no);
        d.month = t_month'(month);
        d.mday  = t_mday'(mday);
        return d;
    endfunction

    task automatic compare_field(string field, t_day day,
                                 int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $display("%0t: day %0d %s expected %0d actual %0d",
                     $time, day, field, expected, actual);
            error_count++;
        end
    endtask

    function automatic t_day random_day();
        int unsigned gy, start;
        case ($urandom_range(0, 9))
            0, 1: return t_day'($urandom_range(0, (1 << bahai_pkg::DAY_W) - 1));
            2, 3, 4: return t_day'($urandom_range(march21_day(bahai_pkg::EPOCH_GREG_YEAR),
                                                  MAX_DAY));
            default: begin
                gy    = $urandom_range(bahai_pkg::EPOCH_GREG_YEAR, 11000);
                start = march21_day(gy);
                if ($urandom_range(0, 1))
                    return t_day'(start - 2 + $urandom_range(0, 4));
                return t_day'(start + 335 + $urandom_range(0, 33));
            end
        endcase
    endfunction

    // Driver: hold an offered transaction until accepted, then pick the next one.
    always @(posedge i_clk) begin : drive_days
        logic        fire, offer;
        t_idle_phase next_phase;
        if (!i_rst_n) begin
            day_chan.valid      <= 1'b0;
            day_chan.day_number <= '0;
        end else begin
            fire = day_chan.valid && day_chan.ready;
            if (fire) begin
                void'(day_queue.pop_front());
                dates_expected.push_back(predict_bahai_date(day_chan.day_number));
                days_sent++;
                next_phase = t_idle_phase'((days_sent * 4) / total_days > 3 ?
                                           3 : (days_sent * 4) / total_days);
                if (next_phase != phase) begin
                    phase         = next_phase;
                    drain_pending = 1'b1;
                end
            end
            if (drain_pending && dates_expected.size() == 0)
                drain_pending = 1'b0;
            if (!day_chan.valid || fire) begin
                offer = day_queue.size() != 0 && !drain_pending;
                if (phase == PH_SENDER_IDLE && $urandom_range(0, 99) < 76)
                    offer = 1'b0;
                if (phase == PH_BOTH_IDLE && $urandom_range(0, 99) < 14)
                    offer = 1'b0;
                day_chan.valid <= offer;
                if (offer)
                    day_chan.day_number <= day_queue[0];
            end
        end
    end

    // Monitor: check each accepted date against the oldest prediction.
    always @(posedge i_clk) begin : watch_dates
        t_bahai_date want;
        logic        accept;
        if (!i_rst_n) begin
            date_chan.ready <= 1'b0;
        end else begin
            if (date_chan.valid && date_chan.ready) begin
                if (dates_expected.size() == 0) begin
                    $display("%0t: unexpected date year %0d month %0d day %0d epoch %0b",
                             $time, date_chan.bahai_year, date_chan.bahai_month,
                             date_chan.bahai_day, date_chan.before_epoch);
                    error_count++;
                end else begin
                    want = dates_expected.pop_front();
                    compare_field("before_epoch", want.day_number, 32'(want.before_epoch),
                                  32'(date_chan.before_epoch));
                    compare_field("year", want.day_number, 32'(want.year),
                                  32'(date_chan.bahai_year));
                    compare_field("month", want.day_number, 32'(want.month),
                                  32'(date_chan.bahai_month));
                    compare_field("day", want.day_number, 32'(want.mday),
                                  32'(date_chan.bahai_day));
                end
            end
            accept = 1'b1;
            if (phase == PH_SINK_STALL && $urandom_range(0, 99) < 76)
                accept = 1'b0;
            if (phase == PH_BOTH_IDLE && $urandom_range(0, 99) < 14)
                accept = 1'b0;
            date_chan.ready <= accept;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned epoch, s;

        epoch = march21_day(bahai_pkg::EPOCH_GREG_YEAR);
        day_queue.push_back(t_day'(0));
        day_queue.push_back(t_day'(1));
        day_queue.push_back(t_day'(epoch - 1));
        day_queue.push_back(t_day'(epoch));
        day_queue.push_back(t_day'(epoch + 18));
        day_queue.push_back(t_day'(epoch + 19));
        day_queue.push_back(t_day'(epoch + 341));
        day_queue.push_back(t_day'(epoch + 342));
        day_queue.push_back(t_day'(epoch + 345));
        day_queue.push_back(t_day'(epoch + 346));
        day_queue.push_back(t_day'(epoch + 364));
        day_queue.push_back(t_day'(epoch + 365));
        s = march21_day(1847);
        day_queue.push_back(t_day'(s + 346));
        day_queue.push_back(t_day'(s + 347));
        day_queue.push_back(t_day'(s + 365));
        s = march21_day(1899);
        day_queue.push_back(t_day'(s + 345));
        day_queue.push_back(t_day'(s + 346));
        s = march21_day(1999);
        day_queue.push_back(t_day'(s + 346));
        day_queue.push_back(t_day'(MAX_DAY));
        day_queue.push_back(t_day'(MAX_DAY + 1));
        day_queue.push_back({bahai_pkg::DAY_W{1'b1}});
        day_queue.push_back({(bahai_pkg::DAY_W / 2){2'b10}});
        day_queue.push_back({(bahai_pkg::DAY_W / 2){2'b01}});
        repeat (RANDOM_ITEMS) day_queue.push_back(random_day());
        total_days = day_queue.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (day_queue.size() != 0) @(posedge i_clk);
        while (dates_expected.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
